[hdl/sliding_window_command_frame_parser_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window command frame parser
// Shared helpers that keep each concurrent check short at the use site.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_COMMAND_FRAME_PARSER_MACROS_SVH
`define SLIDING_WINDOW_COMMAND_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWCFP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swcfp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SWCFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swcfp: next-cycle check failed");

`endif

[hdl/swcfp_pkg.sv]
// ----------------------------------------------------------------------------
// swcfp_pkg
// Types and constants shared by the command frame parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swcfp_pkg;

  localparam int unsigned WinLen = 8;

  localparam logic [7:0] FreqSync = 8'hFF;
  localparam logic [7:0] FreqId   = 8'h48;
  localparam logic [7:0] GainSync = 8'hFC;
  localparam logic [7:0] GainId   = 8'h26;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_FREQ  = 2'd1,
    EV_GAINS = 2'd2
  } event_t;

  typedef struct packed {
    logic [7:0]  gain_d;
    logic [7:0]  gain_i;
    logic [7:0]  gain_p;
    logic [31:0] requested_frequency;
    event_t      event_res;
    logic [7:0]  echo_byte;
    logic        echo_valid;
  } result_t;

endpackage

[hdl/sliding_window_command_frame_parser.sv]
// ----------------------------------------------------------------------------
// sliding_window_command_frame_parser
// Parses frequency and gain command frames from a received byte stream.
//
// Input words on the s_axis channel carry one received byte each. Output
// words on the m_axis channel carry one result per input word: the echo
// flag and byte, the event code, and the stored frequency and gains after
// that byte. The echo mode register is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, as
// the block itself does not enforce this. A word is registered when it is
// accepted and its result is loaded into the output register once that
// register can take it, which raises m_axis_tvalid. One word is accepted
// every cycle, limited only by the output register draining. When the
// receiver holds m_axis_tready low, the output word is held, the input
// register fills and then s_axis_tready drops until the receiver takes
// the word. Reset clears the byte window, the stored frequency and gains,
// the echo mode and both valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sliding_window_command_frame_parser_macros.svh"

module sliding_window_command_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // echo_enable
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] echo_byte, [39:8] requested_frequency, [47:40] gain_p,
  // [55:48] gain_i, [63:56] gain_d
  output logic [63:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser    // [0] echo_valid, [2:1] event_res
);
  import swcfp_pkg::*;

  logic       echo_enable;
  logic       in_valid;
  logic [7:0] rx_byte;
  logic       load_ready;
  logic       advance;
  result_t    result;
  result_t    out_data;

  assign advance       = in_valid && load_ready;
  assign s_axis_tready = !in_valid || load_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      echo_enable <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      rx_byte <= s_axis_tdata;
    end
  end

  swcfp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .echo_enable (echo_enable),
    .rx_byte     (rx_byte),
    .result      (result)
  );

  swcfp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_valid),
    .load_ready (load_ready),
    .load_data  (result),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_data)
  );

  assign m_axis_tdata = {out_data.gain_d, out_data.gain_i, out_data.gain_p,
                         out_data.requested_frequency, out_data.echo_byte};
  assign m_axis_tuser = {out_data.event_res, out_data.echo_valid};

  `SWCFP_ASSERT_IMP(a_echo_no_event, clk, rst,
    m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[2:1] == EV_NONE)
  `SWCFP_ASSERT_IMP(a_parse_zero_byte, clk, rst,
    m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[7:0] == 8'd0)
  `SWCFP_ASSERT_NEXT(a_accept_fills, clk, rst, s_axis_tvalid && s_axis_tready, in_valid)
  `SWCFP_ASSERT_NEXT(a_advance_loads, clk, rst, advance, m_axis_tvalid)

endmodule

[hdl/swcfp_parse.sv]
// ----------------------------------------------------------------------------
// swcfp_parse
// Byte window, frame matching and the stored frequency and gain values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swcfp_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 echo_enable,
  input  logic [7:0]           rx_byte,
  output swcfp_pkg::result_t   result
);
  import swcfp_pkg::*;

  logic [WinLen-1:0][7:0] window;
  logic [WinLen-1:0][7:0] window_next;
  logic [31:0]            freq_store;
  logic [7:0]             p_store;
  logic [7:0]             i_store;
  logic [7:0]             d_store;
  logic [7:0]             sum_gain;
  logic [7:0]             sum_freq;
  logic                   freq_hdr;
  logic                   gain_hdr;
  logic                   freq_hit;
  logic                   gain_hit;

  always_comb begin
    window_next = {rx_byte, window[WinLen-1:1]};
    sum_gain = window_next[1] + window_next[2] + window_next[3]
             + window_next[4] + window_next[5] + window_next[6];
    sum_freq = sum_gain + window_next[7];
    freq_hdr = (window_next[7] == FreqSync) && (window_next[6] == FreqId)
            && (window_next[1] == FreqSync);
    gain_hdr = (window_next[6] == GainSync) && (window_next[5] == GainId)
            && (window_next[1] == GainSync);
    freq_hit = !echo_enable && freq_hdr && (sum_freq == window_next[0]);
    gain_hit = !echo_enable && !freq_hdr && gain_hdr && (sum_gain == window_next[0]);

    result.echo_valid = echo_enable;
    result.echo_byte  = echo_enable ? rx_byte : 8'd0;
    if (freq_hit) begin
      result.event_res = EV_FREQ;
    end else if (gain_hit) begin
      result.event_res = EV_GAINS;
    end else begin
      result.event_res = EV_NONE;
    end
    result.requested_frequency = freq_hit ?
      {window_next[5], window_next[4], window_next[3], window_next[2]} : freq_store;
    result.gain_p = gain_hit ? window_next[2] : p_store;
    result.gain_i = gain_hit ? window_next[3] : i_store;
    result.gain_d = gain_hit ? window_next[4] : d_store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      freq_store <= '0;
      p_store    <= '0;
      i_store    <= '0;
      d_store    <= '0;
    end else if (step && !echo_enable) begin
      window     <= window_next;
      freq_store <= result.requested_frequency;
      p_store    <= result.gain_p;
      i_store    <= result.gain_i;
      d_store    <= result.gain_d;
    end
  end

endmodule

[hdl/swcfp_out_reg.sv]
// ----------------------------------------------------------------------------
// swcfp_out_reg
// Result register that holds a finished word until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swcfp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load_valid,
  output logic                 load_ready,
  input  swcfp_pkg::result_t   load_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output swcfp_pkg::result_t   out_data
);
  import swcfp_pkg::*;

  assign load_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_ready) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      out_data <= load_data;
    end
  end

endmodule

[bench/swcfp_frame_checker.sv]
// ----------------------------------------------------------------------------
// Command frame parser result checker
// Watches the input, output and configuration ports of the frame parser. It
// keeps its own byte window, stored frequency, gains and echo mode, predicts
// one result word for every accepted input word, and compares every accepted
// output word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swcfp_frame_checker
  import swcfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  output int          mismatch_count,
  output int          words_in_flight
);

  logic [7:0]  win [0:7];
  logic [31:0] freq_word;
  logic [7:0]  kp;
  logic [7:0]  ki;
  logic [7:0]  kd;
  logic        echo_on;
  result_t     expected_q [$];
  int          fail_count = 0;

  assign mismatch_count = fail_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic result_t predict_word(input logic [7:0] b);
    result_t    r;
    logic [7:0] csum;
    int         k;
    r = '0;
    r.event_res = EV_NONE;
    if (echo_on) begin
      r.echo_valid = 1'b1;
      r.echo_byte  = b;
    end else begin
      for (k = 0; k < 7; k++) win[k] = win[k + 1];
      win[7] = b;
      if (win[7] == FreqSync && win[6] == FreqId && win[1] == FreqSync) begin
        csum = '0;
        for (k = 1; k <= 7; k++) csum = csum + win[k];
        if (csum == win[0]) begin
          freq_word   = {win[5], win[4], win[3], win[2]};
          r.event_res = EV_FREQ;
        end
      end else if (win[6] == GainSync && win[5] == GainId && win[1] == GainSync) begin
        csum = '0;
        for (k = 1; k <= 6; k++) csum = csum + win[k];
        if (csum == win[0]) begin
          kp = win[2];
          ki = win[3];
          kd = win[4];
          r.event_res = EV_GAINS;
        end
      end
    end
    r.requested_frequency = freq_word;
    r.gain_p = kp;
    r.gain_i = ki;
    r.gain_d = kd;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      k;
    if (rst) begin
      for (k = 0; k < 8; k++) win[k] = '0;
      freq_word = '0;
      kp = '0;
      ki = '0;
      kd = '0;
      echo_on = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) begin
        echo_on = cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("output word with no prediction waiting");
        end else begin
          want = expected_q.pop_front();
          check_field("echo_valid", 32'(m_axis_tuser[0]), 32'(want.echo_valid));
          check_field("event_res", 32'(m_axis_tuser[2:1]), 32'(want.event_res));
          check_field("echo_byte", 32'(m_axis_tdata[7:0]), 32'(want.echo_byte));
          check_field("requested_frequency", m_axis_tdata[39:8],
                      want.requested_frequency);
          check_field("gain_p", 32'(m_axis_tdata[47:40]), 32'(want.gain_p));
          check_field("gain_i", 32'(m_axis_tdata[55:48]), 32'(want.gain_i));
          check_field("gain_d", 32'(m_axis_tdata[63:56]), 32'(want.gain_d));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(predict_word(s_axis_tdata));
      end
    end
    words_in_flight = expected_q.size();
  end

endmodule

[bench/sliding_window_command_frame_parser_test.sv]
// ----------------------------------------------------------------------------
// Command frame parser testbench
// Drives received bytes into the frame parser: a short directed run with
// extreme frames, a bad checksum and echo mode, then random phases mixing
// good frequency and gains frames, damaged frames and noise, in parse and
// echo mode, under several patterns of sender gaps and receiver stalls. A
// separate checker predicts and compares every output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_command_frame_parser_test;
  import swcfp_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  int          mismatch_count;
  int          words_in_flight;

  int          idle_pct;
  int          stall_pct;
  logic [7:0]  frame_bytes [0:7];

  sliding_window_command_frame_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  swcfp_frame_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .mismatch_count  (mismatch_count),
    .words_in_flight (words_in_flight)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_frame();
    int k;
    for (k = 0; k < 8; k++) send_byte(frame_bytes[k]);
  endtask

  task automatic fill_freq_frame(input logic [31:0] freq);
    frame_bytes[1] = FreqSync;
    frame_bytes[2] = freq[7:0];
    frame_bytes[3] = freq[15:8];
    frame_bytes[4] = freq[23:16];
    frame_bytes[5] = freq[31:24];
    frame_bytes[6] = FreqId;
    frame_bytes[7] = FreqSync;
    frame_bytes[0] = frame_bytes[1] + frame_bytes[2] + frame_bytes[3] + frame_bytes[4]
                   + frame_bytes[5] + frame_bytes[6] + frame_bytes[7];
  endtask

  task automatic fill_gains_frame(input logic [7:0] p, input logic [7:0] i,
                                  input logic [7:0] d, input logic [7:0] tail);
    frame_bytes[1] = GainSync;
    frame_bytes[2] = p;
    frame_bytes[3] = i;
    frame_bytes[4] = d;
    frame_bytes[5] = GainId;
    frame_bytes[6] = GainSync;
    frame_bytes[7] = tail;
    frame_bytes[0] = frame_bytes[1] + frame_bytes[2] + frame_bytes[3] + frame_bytes[4]
                   + frame_bytes[5] + frame_bytes[6];
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return FreqSync;
      1: return FreqId;
      2: return GainSync;
      3: return GainId;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_echo_mode(input logic mode);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (words_in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_parse_traffic(input int n_words);
    int sent;
    int pick;
    int k;
    int burst;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 70 || pick < 85) begin
        if ($urandom_range(0, 1) == 0) begin
          fill_freq_frame($urandom());
        end else begin
          fill_gains_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), noise_byte());
        end
        if (pick >= 70) begin
          k = $urandom_range(0, 7);
          frame_bytes[k] = frame_bytes[k] ^ 8'($urandom_range(1, 255));
        end
        send_frame();
        sent += 8;
      end else begin
        burst = $urandom_range(1, 4);
        for (k = 0; k < burst; k++) send_byte(noise_byte());
        sent += burst;
      end
    end
  endtask

  task automatic run_echo_traffic(input int n_words);
    int k;
    for (k = 0; k < n_words; k++) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int phase;
    int idle_tab [0:3];
    int stall_tab [0:3];
    idle_tab  = '{0, 48, 0, 14};
    stall_tab = '{0, 0, 48, 14};
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    write_echo_mode(1'b0);
    fill_freq_frame(32'hFFFF_FFFF);
    send_frame();
    fill_gains_frame(8'h00, 8'hFF, 8'h5A, 8'h00);
    send_frame();
    fill_freq_frame(32'h0000_0000);
    frame_bytes[0] = frame_bytes[0] ^ 8'h01;
    send_frame();
    write_echo_mode(1'b1);
    send_byte(8'h00);
    send_byte(8'hFF);
    write_echo_mode(1'b0);

    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_tab[phase];
      stall_pct = stall_tab[phase];
      run_parse_traffic(100);
      write_echo_mode(1'b1);
      run_echo_traffic(40);
      write_echo_mode(1'b0);
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (words_in_flight != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
